// ===== src/p422_pkg.sv =====
// package for the packed 4:2:2 to planar 4:2:0 converter
// holds register indexes, format codes and the shared item and request types
// no dependencies
package p422_pkg;

	// default line buffer depth in pixel pairs
	localparam int unsigned MAX_PAIRS_DEFAULT = 1024;

	// configuration port widths
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 11;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ORDER  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FORMAT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_PAIRS    = 2'd2;

	// input byte orders; the unused code decodes as yuy2
	localparam logic [1:0] SRC_YUY2 = 2'd0;
	localparam logic [1:0] SRC_UYVY = 2'd1;
	localparam logic [1:0] SRC_YVYU = 2'd2;

	// output formats
	typedef enum logic [1:0] {
		TGT_PLANAR = 2'd0,
		TGT_YUY2   = 2'd1,
		TGT_UYVY   = 2'd2,
		TGT_YVYU   = 2'd3
	} target_t;

	// one decoded pair on its way to the output stage
	// planar mode: b2 and b3 carry the pair's own u and v
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic       planar;
		logic       odd;
		logic       last;
	} item_t;

	// line buffer access for one pair
	typedef struct packed {
		logic        rd;
		logic        we;
		logic [15:0] wdata;
	} lbuf_req_t;

endpackage

// ===== src/p422_lbuf.sv =====
// chroma line buffer: single port synchronous ram with a registered read
// entries hold u in the low byte and v in the high byte
// depends on nothing
module p422_lbuf #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          rd,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	// write and registered read share the address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== src/p422_front.sv =====
// front end: byte order decode, column and row parity counting,
// line buffer request generation; uses p422_pkg
module p422_front #(
	parameter int unsigned AW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [31:0]           pair,
	input  logic [1:0]            source_order,
	input  p422_pkg::target_t     target_format,
	input  logic [AW-1:0]         last_col,
	output p422_pkg::item_t       item,
	output p422_pkg::lbuf_req_t   req,
	output logic [AW-1:0]         col
);

	logic [AW-1:0] col_q;
	logic          odd_q;
	logic [7:0]    y0, y1, u, v;
	logic          last;

	assign col  = col_q;
	assign last = (col_q >= last_col);

	// unpack according to the input order
	always_comb begin
		case (source_order)
			p422_pkg::SRC_UYVY: begin
				u  = pair[7:0];
				y0 = pair[15:8];
				v  = pair[23:16];
				y1 = pair[31:24];
			end
			p422_pkg::SRC_YVYU: begin
				y0 = pair[7:0];
				v  = pair[15:8];
				y1 = pair[23:16];
				u  = pair[31:24];
			end
			default: begin
				y0 = pair[7:0];
				u  = pair[15:8];
				y1 = pair[23:16];
				v  = pair[31:24];
			end
		endcase
	end

	// repack for the target, planar keeps u and v for averaging
	always_comb begin
		item.planar = (target_format == p422_pkg::TGT_PLANAR);
		item.odd    = odd_q;
		item.last   = last;
		case (target_format)
			p422_pkg::TGT_UYVY: begin
				item.b0 = u;
				item.b1 = y0;
				item.b2 = v;
				item.b3 = y1;
			end
			p422_pkg::TGT_YVYU: begin
				item.b0 = y0;
				item.b1 = v;
				item.b2 = y1;
				item.b3 = u;
			end
			p422_pkg::TGT_YUY2: begin
				item.b0 = y0;
				item.b1 = u;
				item.b2 = y1;
				item.b3 = v;
			end
			default: begin
				item.b0 = y0;
				item.b1 = y1;
				item.b2 = u;
				item.b3 = v;
			end
		endcase
	end

	// even planar rows store chroma, odd planar rows fetch it
	always_comb begin
		req.rd    = accept && item.planar && odd_q;
		req.we    = accept && item.planar && !odd_q;
		req.wdata = {v, u};
	end

	// column and row parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				col_q <= '0;
				odd_q <= !odd_q;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/packed_422_to_planar_420_unit.sv =====
// top level of the packed 4:2:2 to planar 4:2:0 converter; uses p422_pkg, p422_front, p422_lbuf
// an input pair passes the stage 1 register and the output register before it is offered
// throughput: one pixel pair per cycle while the output is not stalled; the single line buffer port takes one
// read (odd planar row) or one write (even planar row) per pair
// reset: counters, stage valids and configuration registers return to defaults at once; data registers are not reset;
// line buffer contents are undefined until an even planar row writes them
module packed_422_to_planar_420_unit #(
	parameter int unsigned MAX_PAIRS = p422_pkg::MAX_PAIRS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [p422_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [p422_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input pairs
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [31:0]                      s_axis_tdata,  // byte0, byte1, byte2, byte3
	// output pairs
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [31:0]                      m_axis_tdata,  // out0, out1, out2, out3
	output logic                             m_axis_tuser,  // chroma_valid
	output logic                             m_axis_tlast   // row_end
);

	localparam int unsigned AW = $clog2(MAX_PAIRS);

	logic [1:0]          source_order_q;
	p422_pkg::target_t   target_format_q;
	logic [AW-1:0]       last_col_q;
	logic [AW-1:0]       last_col_next;

	logic                in_xfer;
	logic                adv_s1;
	logic                valid_s1;
	p422_pkg::item_t     item_s1;
	p422_pkg::item_t     item;
	p422_pkg::lbuf_req_t req;
	logic [AW-1:0]       col;
	logic [15:0]         rdata;

	logic                valid_s2;
	logic [31:0]         data_s2;
	logic                user_s2;
	logic                last_s2;
	logic [8:0]          sum_u;
	logic [8:0]          sum_v;

	assign cfg_ready = 1'b1;

	// clamp the line width and keep the last column index
	always_comb begin
		if (cfg_data == '0) begin
			last_col_next = '0;
		end else if (32'(cfg_data) > 32'(MAX_PAIRS)) begin
			last_col_next = AW'(MAX_PAIRS - 1);
		end else begin
			last_col_next = AW'(cfg_data - 1'b1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_order_q  <= p422_pkg::SRC_YUY2;
			target_format_q <= p422_pkg::TGT_PLANAR;
			last_col_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				p422_pkg::REG_SOURCE_ORDER:  source_order_q  <= cfg_data[1:0];
				p422_pkg::REG_TARGET_FORMAT: target_format_q <= p422_pkg::target_t'(cfg_data[1:0]);
				p422_pkg::REG_LINE_PAIRS:    last_col_q      <= last_col_next;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or drains
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	p422_front #(
		.AW (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_xfer),
		.pair          (s_axis_tdata),
		.source_order  (source_order_q),
		.target_format (target_format_q),
		.last_col      (last_col_q),
		.item          (item),
		.req           (req),
		.col           (col)
	);

	p422_lbuf #(
		.DEPTH (MAX_PAIRS),
		.AW    (AW)
	) u_lbuf (
		.clk   (clk),
		.rd    (req.rd),
		.we    (req.we),
		.addr  (col),
		.wdata (req.wdata),
		.rdata (rdata)
	);

	// stage 1: decoded pair, line buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item;
		end
	end

	// floor average of stored and current chroma
	assign sum_u = {1'b0, rdata[7:0]} + {1'b0, item_s1.b2};
	assign sum_v = {1'b0, rdata[15:8]} + {1'b0, item_s1.b3};

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			last_s2 <= item_s1.last;
			if (!item_s1.planar) begin
				data_s2 <= {item_s1.b3, item_s1.b2, item_s1.b1, item_s1.b0};
				user_s2 <= 1'b0;
			end else if (item_s1.odd) begin
				data_s2 <= {sum_v[8:1], sum_u[8:1], item_s1.b1, item_s1.b0};
				user_s2 <= 1'b1;
			end else begin
				data_s2 <= {16'h0000, item_s1.b1, item_s1.b0};
				user_s2 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;
	assign m_axis_tlast  = last_s2;

`ifndef NO_ASSERTIONS
	// a pair either reads or writes the line buffer, never both
	assert property (@(posedge clk) disable iff (!arst_n) !(req.rd && req.we))
		else $error("line buffer read and write in one cycle");

	// a row end wraps the column counter
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && item.last |=> col == '0)
		else $error("column did not wrap after row end");

	// otherwise the column steps by one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !item.last |=> col == $past(col) + 1'b1)
		else $error("column did not advance");

	// a stalled stage 1 keeps its pair, so the read data is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !in_xfer && !req.rd)
		else $error("input taken while stage 1 is stalled");
`endif

endmodule
